// ===== hdl/csem_pkg.sv =====
// shared types, codes and constants of the counting semaphore unit
package csem_pkg;

    // field and storage widths
    localparam int ACT_W      = 2;
    localparam int RES_W      = 2;
    localparam int PID_W      = 4;
    localparam int STAT_W     = 2;
    localparam int HELD_W     = 4;
    localparam int CNT_W      = 8;
    localparam int INIT_W     = 7;
    localparam int QDEPTH     = 16;
    localparam int QPTR_W     = 4;
    localparam int OCC_W      = 5;
    localparam int RIU_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // default sizing of the top level
    localparam int NUM_RESOURCES_DEF = 4;
    localparam int NUM_PROCESSES_DEF = 16;
    localparam int MAX_HELD_DEF      = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_IN_USE = 3'd4;
    localparam logic [RIU_W-1:0]     RIU_RESET      = 3'd4;

    // saturation limits of the signed instance counter, as bit patterns
    localparam logic [CNT_W-1:0] CNT_MAX   = 8'h7f;
    localparam logic [CNT_W-1:0] CNT_MIN   = 8'h80;
    localparam logic [CNT_W-1:0] CNT_RESET = 8'h01;

    typedef enum logic [ACT_W-1:0] {
        ACT_WAIT    = 2'd0,
        ACT_SIGNAL  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_OVERFLOW  = 2'd2,
        STS_NONE_HELD = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BAD,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_SKIP,
        S_NONE
    } state_t;

    // sequencer outputs to the datapath
    typedef struct packed {
        logic in_ready;
        logic clearing;
        logic scanning;
        logic skipping;
        logic exec;
        logic emit_bad;
        logic emit_none;
    } ctl_t;

    // datapath status to the sequencer
    typedef struct packed {
        logic    accept;
        action_t new_act;
        logic    new_bad;
        action_t cur_act;
        logic    clear_done;
        logic    scan_done;
        logic    out_free;
        logic    skip_hit;
        logic    skip_end;
        logic    exec_more;
        logic    exec_last;
    } sts_t;

    // counter load request from a configuration write
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  idx;
        logic [INIT_W-1:0]     value;
    } cfg_load_t;

endpackage

// ===== hdl/csem_ifs.sv =====
// request and result channel interfaces of the counting semaphore unit
interface csem_req_if import csem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [RES_W-1:0] resource_index;
    logic [PID_W-1:0] process_id;

    modport source (output valid, action, resource_index, process_id, input ready);
    modport sink   (input valid, action, resource_index, process_id, output ready);
    modport mon    (input valid, ready, action, resource_index, process_id);
endinterface

interface csem_res_if import csem_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    logic              blocked;
    logic              woken_valid;
    logic [PID_W-1:0]  woken_process;
    logic [RES_W-1:0]  released_resource;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, granted, blocked, woken_valid, woken_process,
                    released_resource, status, last, input ready);
    modport sink   (input valid, granted, blocked, woken_valid, woken_process,
                    released_resource, status, last, output ready);
    modport mon    (input valid, ready, granted, blocked, woken_valid, woken_process,
                    released_resource, status, last);
endinterface

// ===== hdl/csem_ram.sv =====
// generic simple dual-port ram with registered read
module csem_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/csem_cfg.sv =====
// configuration register decode and resource limit of the semaphore unit
module csem_cfg import csem_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    localparam int LIM_W        = $clog2(NUM_RESOURCES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_load_t             load,
    output logic [LIM_W-1:0]      limit
);

    logic [RIU_W-1:0] riu_reg;
    logic [RIU_W-1:0] riu_next;

    // resources in use register
    always_comb
    begin
        riu_next = riu_reg;
        if (cfg_we && (cfg_index == CFG_RES_IN_USE))
        begin
            riu_next = cfg_data[RIU_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riu_reg <= RIU_RESET;
        end
        else
        begin
            riu_reg <= riu_next;
        end
    end

    // a write of an initial count reloads that counter
    always_comb
    begin
        load.valid = cfg_we && (cfg_index <= CFG_INIT_LAST);
        load.idx   = cfg_index;
        load.value = cfg_data[INIT_W-1:0];
    end

    // valid resource slots, bounded by the built resource count
    always_comb
    begin
        if (int'(riu_reg) < NUM_RESOURCES)
        begin
            limit = LIM_W'(riu_reg);
        end
        else
        begin
            limit = LIM_W'(NUM_RESOURCES);
        end
    end

endmodule

// ===== hdl/csem_fsm.sv =====
// sequencer of the semaphore unit: clearing, read, execute and release walk
module csem_fsm import csem_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sts.accept)
                begin
                    if (sts.new_act == ACT_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.new_bad)
                    begin
                        state_next = S_BAD;
                    end
                    else if (sts.new_act == ACT_RELEASE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_BAD, S_NONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    if ((sts.cur_act != ACT_RELEASE) || sts.exec_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.exec_more)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (sts.skip_hit)
                begin
                    state_next = S_READ;
                end
                else if (sts.skip_end)
                begin
                    state_next = S_NONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state decode
    always_comb
    begin
        ctl           = '0;
        ctl.in_ready  = (state_reg == S_IDLE);
        ctl.clearing  = (state_reg == S_CLEAR);
        ctl.scanning  = (state_reg == S_SCAN);
        ctl.skipping  = (state_reg == S_SKIP);
        ctl.exec      = (state_reg == S_EXEC);
        ctl.emit_bad  = (state_reg == S_BAD);
        ctl.emit_none = (state_reg == S_NONE);
    end

endmodule

// ===== hdl/counting_semaphore_wait_queues.sv =====
// counting semaphore unit with per-resource fifo wait queues held in two synchronous rams
// wait and signal: accept, ram read and execute steps, execute waiting for a free output register;
//   the result then sits in that register, and the next request is taken while it waits
// release all: an accept step, a scan of the held counts, a step per resource visited, then
//   a read step and an execute step per released unit, for the read-then-write pass through the queue ram
// reset: asynchronous, active low; then a clearing pass over the held-unit ram of
//   NUM_PROCESSES * 2**ceil(log2 NUM_RESOURCES) entries (64 by default) with req.ready low
module counting_semaphore_wait_queues import csem_pkg::*; #(
    parameter int NUM_RESOURCES         = NUM_RESOURCES_DEF,
    parameter int NUM_PROCESSES         = NUM_PROCESSES_DEF,
    parameter int MAX_HELD_PER_RESOURCE = MAX_HELD_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    csem_req_if.sink              req,
    csem_res_if.source            res
);

    localparam int RIDX_W       = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PIDX_W       = $clog2(NUM_PROCESSES);
    localparam int HA_W         = PIDX_W + RIDX_W;
    localparam int HELD_DEPTH   = NUM_PROCESSES * (2 ** RIDX_W);
    localparam int QA_W         = RIDX_W + QPTR_W;
    localparam int QSTORE_DEPTH = (2 ** RIDX_W) * QDEPTH;
    localparam int SCAN_W       = $clog2(NUM_RESOURCES + 1);

    localparam logic [RIDX_W-1:0] LAST_RES  = RIDX_W'(NUM_RESOURCES - 1);
    localparam logic [HA_W-1:0]   LAST_CLR  = HA_W'(HELD_DEPTH - 1);
    localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(NUM_RESOURCES);
    localparam logic [HELD_W-1:0] MAX_HELD  = HELD_W'(MAX_HELD_PER_RESOURCE);
    localparam logic [HELD_W-1:0] HELD_ONE  = HELD_W'(1);
    localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(QDEPTH);

    ctl_t               ctl;
    sts_t               sts;
    cfg_load_t          cfg_load;
    logic [SCAN_W-1:0]  limit;

    // item registers
    action_t            act_reg, act_next;
    logic [PIDX_W-1:0]  proc_reg, proc_next;
    logic [RIDX_W-1:0]  cur_r_reg, cur_r_next;
    logic [SCAN_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [HA_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [HELD_W-1:0]  held_cnt_reg [NUM_RESOURCES];
    logic [HELD_W-1:0]  held_cnt_next [NUM_RESOURCES];

    // per-resource state
    logic [CNT_W-1:0]   counter_reg [NUM_RESOURCES];
    logic [CNT_W-1:0]   counter_next [NUM_RESOURCES];
    logic [QPTR_W-1:0]  head_reg [NUM_RESOURCES];
    logic [QPTR_W-1:0]  head_next [NUM_RESOURCES];
    logic [QPTR_W-1:0]  tail_reg [NUM_RESOURCES];
    logic [QPTR_W-1:0]  tail_next [NUM_RESOURCES];
    logic [OCC_W-1:0]   occ_reg [NUM_RESOURCES];
    logic [OCC_W-1:0]   occ_next [NUM_RESOURCES];

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               granted_reg, granted_next;
    logic               blocked_reg, blocked_next;
    logic               woken_valid_reg, woken_valid_next;
    logic [PID_W-1:0]   woken_process_reg, woken_process_next;
    logic [RES_W-1:0]   released_reg, released_next;
    status_t            status_reg, status_next;
    logic               last_reg, last_next;

    // ram ports
    logic               held_we;
    logic [HA_W-1:0]    held_waddr;
    logic [HELD_W-1:0]  held_wdata;
    logic [HA_W-1:0]    held_raddr;
    logic [HELD_W-1:0]  held_rd;
    logic               q_we;
    logic [QA_W-1:0]    q_waddr;
    logic [QA_W-1:0]    q_raddr;
    logic [PID_W-1:0]   q_rd;

    // execute-step terms
    logic               in_acc;
    logic               in_bad;
    logic               out_free;
    logic               exec_fire;
    logic               emit_fire;
    logic               is_wait;
    logic               is_release;
    logic [HELD_W-1:0]  h_cur;
    logic [CNT_W-1:0]   cnt_cur;
    logic [OCC_W-1:0]   occ_cur;
    logic               grant;
    logic               wait_ovf;
    logic               q_nonempty;
    logic               more_later;
    logic               exec_last;
    logic [SCAN_W-1:0]  scan_prev;

    csem_cfg #(
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load      (cfg_load),
        .limit     (limit)
    );

    csem_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    // held units per process and resource
    csem_ram #(
        .WIDTH (HELD_W),
        .DEPTH (HELD_DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (held_raddr),
        .rdata (held_rd)
    );

    // wait queue entries, sixteen per resource
    csem_ram #(
        .WIDTH (PID_W),
        .DEPTH (QSTORE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (PID_W'(proc_reg)),
        .raddr (q_raddr),
        .rdata (q_rd)
    );

    // request handshake and validity check
    assign req.ready = ctl.in_ready;
    assign in_acc    = req.valid && ctl.in_ready;
    assign in_bad    = (int'(req.process_id) >= NUM_PROCESSES) ||
                       ((req.action != ACT_RELEASE) &&
                        (int'(req.resource_index) >= int'(limit)));

    assign out_free  = !out_valid_reg || res.ready;
    assign exec_fire = ctl.exec && out_free;
    assign emit_fire = (ctl.exec || ctl.emit_bad || ctl.emit_none) && out_free;

    // current resource view
    assign is_wait    = (act_reg == ACT_WAIT);
    assign is_release = (act_reg == ACT_RELEASE);
    assign h_cur      = is_release ? held_cnt_reg[cur_r_reg] : held_rd;
    assign cnt_cur    = counter_reg[cur_r_reg];
    assign occ_cur    = occ_reg[cur_r_reg];
    assign grant      = !cnt_cur[CNT_W-1] && (cnt_cur != '0);
    assign wait_ovf   = (h_cur >= MAX_HELD) || (!grant && (occ_cur == OCC_FULL));
    assign q_nonempty = (occ_cur != '0);
    assign scan_prev  = scan_idx_reg - SCAN_W'(1);

    // any units left on higher resources during a release walk
    always_comb
    begin
        more_later = 1'b0;
        for (int k = 0; k < NUM_RESOURCES; k++)
        begin
            if ((k > int'(cur_r_reg)) && (held_cnt_reg[k] != '0))
            begin
                more_later = 1'b1;
            end
        end
    end

    assign exec_last = (h_cur == HELD_ONE) && !more_later;

    // status to the sequencer
    always_comb
    begin
        sts.accept     = in_acc;
        sts.new_act    = action_t'(req.action);
        sts.new_bad    = in_bad;
        sts.cur_act    = act_reg;
        sts.clear_done = (clr_idx_reg == LAST_CLR);
        sts.scan_done  = (scan_idx_reg == SCAN_END);
        sts.out_free   = out_free;
        sts.skip_hit   = (held_cnt_reg[cur_r_reg] != '0);
        sts.skip_end   = (cur_r_reg == LAST_RES);
        sts.exec_more  = (h_cur > HELD_ONE);
        sts.exec_last  = exec_last;
    end

    // held ram: clearing sweep, then read-modify-write of the current entry
    always_comb
    begin
        held_we    = 1'b0;
        held_waddr = {proc_reg, cur_r_reg};
        held_wdata = h_cur - HELD_W'(h_cur != '0);
        if (ctl.clearing)
        begin
            held_we    = 1'b1;
            held_waddr = clr_idx_reg;
            held_wdata = '0;
        end
        else if (exec_fire)
        begin
            if (is_wait)
            begin
                held_we    = !wait_ovf;
                held_wdata = h_cur + HELD_ONE;
            end
            else
            begin
                held_we = 1'b1;
            end
        end
    end

    assign held_raddr = ctl.scanning ? {proc_reg, scan_idx_reg[RIDX_W-1:0]}
                                     : {proc_reg, cur_r_reg};

    // queue ram: enqueue at tail on a blocking wait, head always being read
    assign q_we    = exec_fire && is_wait && !wait_ovf && !grant;
    assign q_waddr = {cur_r_reg, tail_reg[cur_r_reg]};
    assign q_raddr = {cur_r_reg, head_reg[cur_r_reg]};

    // next state of item and resource registers
    always_comb
    begin
        act_next      = act_reg;
        proc_next     = proc_reg;
        cur_r_next    = cur_r_reg;
        scan_idx_next = scan_idx_reg;
        clr_idx_next  = clr_idx_reg;
        held_cnt_next = held_cnt_reg;
        counter_next  = counter_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;

        // clearing sweep address
        if (ctl.clearing)
        begin
            clr_idx_next = clr_idx_reg + HA_W'(1);
        end

        // latch an accepted transaction
        if (in_acc)
        begin
            act_next      = action_t'(req.action);
            proc_next     = PIDX_W'(req.process_id);
            scan_idx_next = '0;
            if (req.action == ACT_RELEASE)
            begin
                cur_r_next = '0;
            end
            else
            begin
                cur_r_next = RIDX_W'(req.resource_index);
            end
        end

        // prescan of held counts, one read a cycle
        if (ctl.scanning)
        begin
            scan_idx_next = scan_idx_reg + SCAN_W'(1);
            if (scan_idx_reg != '0)
            begin
                held_cnt_next[scan_prev[RIDX_W-1:0]] = held_rd;
            end
        end

        // step past resources with nothing held
        if (ctl.skipping && !sts.skip_hit && !sts.skip_end)
        begin
            cur_r_next = cur_r_reg + RIDX_W'(1);
        end

        // execute step
        if (exec_fire)
        begin
            if (is_wait)
            begin
                if (!wait_ovf)
                begin
                    if (!grant)
                    begin
                        tail_next[cur_r_reg] = tail_reg[cur_r_reg] + QPTR_W'(1);
                        occ_next[cur_r_reg]  = occ_cur + OCC_W'(1);
                    end
                    if (cnt_cur != CNT_MIN)
                    begin
                        counter_next[cur_r_reg] = cnt_cur - CNT_W'(1);
                    end
                end
            end
            else
            begin
                if (cnt_cur != CNT_MAX)
                begin
                    counter_next[cur_r_reg] = cnt_cur + CNT_W'(1);
                end
                if (q_nonempty)
                begin
                    head_next[cur_r_reg] = head_reg[cur_r_reg] + QPTR_W'(1);
                    occ_next[cur_r_reg]  = occ_cur - OCC_W'(1);
                end
                if (is_release)
                begin
                    held_cnt_next[cur_r_reg] = h_cur - HELD_ONE;
                    if ((h_cur == HELD_ONE) && !exec_last)
                    begin
                        cur_r_next = cur_r_reg + RIDX_W'(1);
                    end
                end
            end
        end

        // configuration write reloads a counter
        for (int k = 0; k < NUM_RESOURCES; k++)
        begin
            if (cfg_load.valid && (int'(cfg_load.idx) == k))
            begin
                counter_next[k] = CNT_W'(cfg_load.value);
            end
        end
    end

    // result formation into the output register
    always_comb
    begin
        out_valid_next     = out_valid_reg && !res.ready;
        granted_next       = granted_reg;
        blocked_next       = blocked_reg;
        woken_valid_next   = woken_valid_reg;
        woken_process_next = woken_process_reg;
        released_next      = released_reg;
        status_next        = status_reg;
        last_next          = last_reg;
        if (emit_fire)
        begin
            out_valid_next     = 1'b1;
            granted_next       = 1'b0;
            blocked_next       = 1'b0;
            woken_valid_next   = 1'b0;
            woken_process_next = '0;
            released_next      = '0;
            status_next        = STS_OK;
            last_next          = 1'b1;
            if (ctl.emit_bad)
            begin
                status_next = STS_BAD_INDEX;
            end
            else if (ctl.emit_none)
            begin
                status_next = STS_NONE_HELD;
            end
            else if (is_wait)
            begin
                if (wait_ovf)
                begin
                    status_next = STS_OVERFLOW;
                end
                else
                begin
                    granted_next = grant;
                    blocked_next = !grant;
                end
            end
            else
            begin
                woken_valid_next   = q_nonempty;
                woken_process_next = q_nonempty ? q_rd : '0;
                released_next      = RES_W'(cur_r_reg);
                last_next          = !is_release || exec_last;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= ACT_NONE;
            cur_r_reg     <= '0;
            scan_idx_reg  <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_RESOURCES; k++)
            begin
                counter_reg[k] <= CNT_RESET;
                head_reg[k]    <= '0;
                tail_reg[k]    <= '0;
                occ_reg[k]     <= '0;
            end
        end
        else
        begin
            act_reg       <= act_next;
            cur_r_reg     <= cur_r_next;
            scan_idx_reg  <= scan_idx_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            counter_reg   <= counter_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        proc_reg          <= proc_next;
        held_cnt_reg      <= held_cnt_next;
        granted_reg       <= granted_next;
        blocked_reg       <= blocked_next;
        woken_valid_reg   <= woken_valid_next;
        woken_process_reg <= woken_process_next;
        released_reg      <= released_next;
        status_reg        <= status_next;
        last_reg          <= last_next;
    end

    // result channel
    assign res.valid             = out_valid_reg;
    assign res.granted           = granted_reg;
    assign res.blocked           = blocked_reg;
    assign res.woken_valid       = woken_valid_reg;
    assign res.woken_process     = woken_process_reg;
    assign res.released_resource = released_reg;
    assign res.status            = status_reg;
    assign res.last              = last_reg;

endmodule

// ===== hdl/csem_chk.sv =====
// port-level checks of the semaphore unit, bound to the top level
module csem_chk import csem_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    csem_req_if.sink   req,
    csem_res_if.source res
);

    // a stalled result keeps its contents
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.status) &&
        $stable(res.woken_process) && $stable(res.last))
        else $error("result changed while stalled");

    // a wait outcome is exclusive, successful and single
    a_wait_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.granted || res.blocked) |->
        !(res.granted && res.blocked) && (res.status == STS_OK) && res.last &&
        !res.woken_valid)
        else $error("malformed wait result");

    // any error ends the transaction and wakes nobody
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status != STS_OK) |->
        res.last && !res.woken_valid && (res.woken_process == '0))
        else $error("error result not final or with a wake-up");

    // a transaction that does work keeps the request side closed the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.action != ACT_NONE) |=> !req.ready)
        else $error("request accepted while busy");

endmodule

bind counting_semaphore_wait_queues csem_chk u_csem_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
);
